// File: hdl/lpq_pkg.sv
// shared types and codes for the looping play queue
// used by the controller, datapath and top level
package lpq_pkg;

  localparam int ID_W       = 16;
  localparam int CMD_W      = 3;
  localparam int ROW_W      = 4;
  localparam int SLOT_W     = 2;
  localparam int STATUS_W   = 4;
  localparam int PUSHED_W   = 2;
  localparam int NSONGS_W   = 16;
  localparam int NGROUPS_W  = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SONGS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GROUPS = 2'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_TOGGLE = 3'd2,
    CMD_PUSH   = 3'd3,
    CMD_GROUP  = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 4'd0,
    STS_POPPED    = 4'd1,
    STS_EMPTY     = 4'd2,
    STS_LOOP_ON   = 4'd3,
    STS_LOOP_OFF  = 4'd4,
    STS_FULL      = 4'd5,
    STS_BAD_ID    = 4'd6,
    STS_BAD_GROUP = 4'd7,
    STS_TABLE_BAD = 4'd8
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_GRD,
    S_GWR,
    S_GFIN
  } state_t;

  typedef struct packed {
    logic imm;
    logic pop_rd;
    logic pop_fin;
    logic grp_clr;
    logic grp_rd;
    logic grp_wr;
    logic grp_fin;
  } ctrl_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             tbad;
    logic             empty;
    logic             full;
    logic             row_ok;
    logic             grp_last;
    logic             out_free;
  } stat_t;

endpackage

// File: hdl/looping_play_queue_top.sv
// Looping play queue: a circular queue of ids with recirculation and a group table.
// One request gives one result. Load, push, toggle and rejected requests are handled
// straight from the idle state; a pop first does a registered read of the queue memory;
// a group push reads each table id from the table memory and then writes it into the
// queue, and the try that finds the queue full also goes through the read and write steps.
// Requests are taken one at a time, and only while the result register is empty or
// being read, so a stalled result holds off the next request.
// Depends on lpq_pkg, lpq_ctrl, lpq_datapath.
module looping_play_queue_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_GROUPS  = 16,
  parameter int GROUP_SIZE  = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // command[2:0], song_id[18:3], group_index[22:19], slot[24:23], zero fill
  input  logic [lpq_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // status[3:0], popped_id[19:4], pushed_count[21:20], zero fill
  output logic [lpq_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lpq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpq_pkg::CFG_DATA_W-1:0] cfg_data
);

  import lpq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  assign cfg_ready = 1'b1;

  lpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  lpq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_GROUPS  (MAX_GROUPS),
    .GROUP_SIZE  (GROUP_SIZE)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .ctrl       (ctrl),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> (!out_tvalid || out_tready))
    else $error("request taken while result register is blocked");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty))
    else $error("queue full and empty at once");

  a_popped_only_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[3:0] != STS_POPPED) |-> (out_tdata[19:4] == '0))
    else $error("popped id without a pop");

  a_pushed_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[21:20] != '0) |->
      (out_tdata[3:0] == STS_OK || out_tdata[3:0] == STS_POPPED ||
       out_tdata[3:0] == STS_FULL))
    else $error("pushed count with a rejecting status");

endmodule

// File: hdl/lpq_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module lpq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/lpq_datapath.sv
// fifo and group table storage, pointers, config registers and result register
// depends on lpq_pkg and lpq_ram
module lpq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int MAX_GROUPS  = 16,
  parameter int GROUP_SIZE  = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [lpq_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic                              cfg_valid,
  input  logic [lpq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lpq_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  lpq_pkg::ctrl_t                    ctrl,
  output lpq_pkg::stat_t                    stat,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lpq_pkg::OUT_DATA_W-1:0]    out_tdata
);

  import lpq_pkg::*;

  localparam int QAW   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int TBL_D = MAX_GROUPS * GROUP_SIZE;
  localparam int TAW   = (TBL_D > 1) ? $clog2(TBL_D) : 1;
  localparam int GI_W  = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    logic [QAW-1:0] r;
    if (p == QAW'(QUEUE_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + QAW'(1);
    end
    return r;
  endfunction

  logic [CMD_W-1:0]  in_cmd;
  logic [ID_W-1:0]   in_id;
  logic [ROW_W-1:0]  in_row;
  logic [SLOT_W-1:0] in_slot;

  assign in_cmd  = in_tdata[2:0];
  assign in_id   = in_tdata[18:3];
  assign in_row  = in_tdata[22:19];
  assign in_slot = in_tdata[24:23];

  logic [QAW-1:0]       head_r, head_nxt, tail_r, tail_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 rec_r, rec_nxt, tbad_r, tbad_nxt;
  logic [NSONGS_W-1:0]  num_songs_r, num_songs_nxt;
  logic [NGROUPS_W-1:0] num_groups_r, num_groups_nxt;
  logic [ROW_W-1:0]     row_r, row_nxt;
  logic [GI_W-1:0]      gi_r, gi_nxt;
  logic [PUSHED_W-1:0]  gcnt_r, gcnt_nxt;
  logic                 gfull_r, gfull_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [ID_W-1:0]      out_pop_r, out_pop_nxt;
  logic [PUSHED_W-1:0]  out_push_r, out_push_nxt;

  logic            fifo_we, fifo_re;
  logic [QAW-1:0]  fifo_waddr;
  logic [ID_W-1:0] fifo_wdata, fifo_rdata;
  logic            tbl_we, tbl_re;
  logic [TAW-1:0]  tbl_waddr, tbl_raddr;
  logic [ID_W-1:0] tbl_rdata;

  logic full, empty, row_ok_in, slot_ok, out_free;

  assign full      = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (cnt_r == '0);
  assign row_ok_in = ({1'b0, in_row} < num_groups_r) && (int'(in_row) < MAX_GROUPS);
  assign slot_ok   = (int'(in_slot) < GROUP_SIZE);
  assign out_free  = !out_tvalid_r || out_tready;

  assign tbl_waddr = TAW'(int'(in_row) * GROUP_SIZE + int'(in_slot));
  assign tbl_raddr = TAW'(int'(row_r) * GROUP_SIZE + int'(gi_r));

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    rec_nxt        = rec_r;
    tbad_nxt       = tbad_r;
    num_songs_nxt  = num_songs_r;
    num_groups_nxt = num_groups_r;
    row_nxt        = row_r;
    gi_nxt         = gi_r;
    gcnt_nxt       = gcnt_r;
    gfull_nxt      = gfull_r;
    out_status_nxt = out_status_r;
    out_pop_nxt    = out_pop_r;
    out_push_nxt   = out_push_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    fifo_we        = 1'b0;
    fifo_re        = 1'b0;
    fifo_waddr     = tail_r;
    fifo_wdata     = in_id;
    tbl_we         = 1'b0;
    tbl_re         = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NUM_SONGS:  num_songs_nxt  = cfg_data;
        CFG_NUM_GROUPS: num_groups_nxt = cfg_data[NGROUPS_W-1:0];
        default: ;
      endcase
    end

    if (ctrl.imm) begin
      out_tvalid_nxt = 1'b1;
      out_pop_nxt    = '0;
      out_push_nxt   = '0;
      out_status_nxt = STS_OK;
      if (tbad_r) begin
        out_status_nxt = STS_TABLE_BAD;
      end else begin
        unique case (in_cmd)
          CMD_LOAD: begin
            if (!row_ok_in || !slot_ok) begin
              out_status_nxt = STS_BAD_GROUP;
            end else begin
              tbl_we = 1'b1;
              if (in_id >= num_songs_r) begin
                tbad_nxt       = 1'b1;
                out_status_nxt = STS_TABLE_BAD;
              end
            end
          end
          CMD_POP:    out_status_nxt = STS_EMPTY;
          CMD_TOGGLE: begin
            rec_nxt        = !rec_r;
            out_status_nxt = rec_r ? STS_LOOP_OFF : STS_LOOP_ON;
          end
          CMD_PUSH: begin
            if (full) begin
              out_status_nxt = STS_FULL;
            end else if (in_id >= num_songs_r) begin
              out_status_nxt = STS_BAD_ID;
            end else begin
              fifo_we      = 1'b1;
              tail_nxt     = ptr_inc(tail_r);
              cnt_nxt      = cnt_r + CNT_W'(1);
              out_push_nxt = PUSHED_W'(1);
            end
          end
          CMD_GROUP:  out_status_nxt = STS_BAD_GROUP;
          default: ;
        endcase
      end
    end

    if (ctrl.pop_rd) begin
      fifo_re = 1'b1;
    end

    if (ctrl.pop_fin) begin
      out_tvalid_nxt = 1'b1;
      out_status_nxt = STS_POPPED;
      out_pop_nxt    = fifo_rdata;
      out_push_nxt   = '0;
      head_nxt       = ptr_inc(head_r);
      if (rec_r) begin
        fifo_we      = 1'b1;
        fifo_wdata   = fifo_rdata;
        tail_nxt     = ptr_inc(tail_r);
        out_push_nxt = PUSHED_W'(1);
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end

    if (ctrl.grp_clr) begin
      row_nxt   = in_row;
      gi_nxt    = '0;
      gcnt_nxt  = '0;
      gfull_nxt = 1'b0;
    end

    if (ctrl.grp_rd) begin
      tbl_re = 1'b1;
    end

    if (ctrl.grp_wr) begin
      if (full) begin
        gfull_nxt = 1'b1;
      end else begin
        fifo_we    = 1'b1;
        fifo_wdata = tbl_rdata;
        tail_nxt   = ptr_inc(tail_r);
        cnt_nxt    = cnt_r + CNT_W'(1);
        gi_nxt     = gi_r + GI_W'(1);
        gcnt_nxt   = gcnt_r + PUSHED_W'(1);
      end
    end

    if (ctrl.grp_fin) begin
      out_tvalid_nxt = 1'b1;
      out_status_nxt = gfull_r ? STS_FULL : STS_OK;
      out_pop_nxt    = '0;
      out_push_nxt   = gcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      rec_r        <= 1'b0;
      tbad_r       <= 1'b0;
      num_songs_r  <= NSONGS_W'(1);
      num_groups_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      rec_r        <= rec_nxt;
      tbad_r       <= tbad_nxt;
      num_songs_r  <= num_songs_nxt;
      num_groups_r <= num_groups_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r        <= row_nxt;
    gi_r         <= gi_nxt;
    gcnt_r       <= gcnt_nxt;
    gfull_r      <= gfull_nxt;
    out_status_r <= out_status_nxt;
    out_pop_r    <= out_pop_nxt;
    out_push_r   <= out_push_nxt;
  end

  lpq_ram #(
    .WIDTH (ID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (fifo_waddr),
    .wdata (fifo_wdata),
    .re    (fifo_re),
    .raddr (head_r),
    .rdata (fifo_rdata)
  );

  lpq_ram #(
    .WIDTH (ID_W),
    .DEPTH (TBL_D)
  ) u_table_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (in_id),
    .re    (tbl_re),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  assign stat.cmd      = in_cmd;
  assign stat.tbad     = tbad_r;
  assign stat.empty    = empty;
  assign stat.full     = full;
  assign stat.row_ok   = row_ok_in;
  assign stat.grp_last = (gi_r == GI_W'(GROUP_SIZE - 1));
  assign stat.out_free = out_free;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_push_r, out_pop_r, out_status_r};

endmodule

// File: hdl/lpq_ctrl.sv
// command sequencer for the looping play queue
// depends on lpq_pkg
module lpq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lpq_pkg::stat_t stat,
  output lpq_pkg::ctrl_t ctrl
);

  import lpq_pkg::*;

  state_t state_r, state_nxt;
  logic   take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    in_tready = 1'b0;
    take      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = stat.out_free;
        take      = in_tvalid && stat.out_free;
        if (take) begin
          if (!stat.tbad && stat.cmd == CMD_POP && !stat.empty) begin
            ctrl.pop_rd = 1'b1;
            state_nxt   = S_POP;
          end else if (!stat.tbad && stat.cmd == CMD_GROUP && stat.row_ok) begin
            ctrl.grp_clr = 1'b1;
            state_nxt    = S_GRD;
          end else begin
            ctrl.imm = 1'b1;
          end
        end
      end
      S_POP: begin
        if (stat.out_free) begin
          ctrl.pop_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_GRD: begin
        ctrl.grp_rd = 1'b1;
        state_nxt   = S_GWR;
      end
      S_GWR: begin
        ctrl.grp_wr = 1'b1;
        state_nxt   = (stat.full || stat.grp_last) ? S_GFIN : S_GRD;
      end
      S_GFIN: begin
        if (stat.out_free) begin
          ctrl.grp_fin = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps
// testbench for looping_play_queue_top: a short directed table around random
// request phases checked against an in-bench predictor; needs lpq_pkg and the rtl
module tb_top;
  import lpq_pkg::*;

  localparam int DEPTH  = 16;
  localparam int GRP_SZ = 3;
  localparam int LIMIT  = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_LEN = 210;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  row;
    logic [ID_W-1:0]   song;
    logic [CMD_W-1:0]  cmd;
  } req_t;

  typedef struct packed {
    logic [PUSHED_W-1:0] pushed;
    logic [ID_W-1:0]     popped;
    logic [STATUS_W-1:0] status;
  } res_t;

  typedef struct packed {
    logic                  is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    req_t                  r;
    logic                  typed;
    res_t                  res;
  } step_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  looping_play_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predicted queue state, updated on each accepted request or register write
  logic [ID_W-1:0]      song_mem [DEPTH];
  logic [3:0]           song_head;
  logic [3:0]           song_tail;
  logic [4:0]           song_fill;
  logic                 loop_on;
  logic [ID_W-1:0]      group_tbl [16*GRP_SZ];
  logic                 tbl_broken;
  logic [NSONGS_W-1:0]  cur_songs;
  logic [NGROUPS_W-1:0] cur_groups;

  // stimulus side view of the table and registers
  logic [GRP_SZ-1:0]    row_loaded [16];
  logic [NSONGS_W-1:0]  drv_songs;
  logic [NGROUPS_W-1:0] drv_groups;
  logic                 push_heavy;
  int                   send_idle;
  int                   stall_pct;
  logic                 req_typed;
  res_t                 req_res;

  res_t pending_results [$];
  step_t steps [$];
  int   mismatches;
  int   cycle_count;
  res_t got_res;
  res_t want_res;
  res_t calc_res;

  always #10 clk = ~clk;

  task automatic store_song(input logic [ID_W-1:0] s);
    song_mem[song_tail] = s;
    song_tail = song_tail + 1'b1;
    song_fill = song_fill + 1'b1;
  endtask

  task automatic advance_play_queue(input req_t r, output res_t o);
    int   k;
    logic stop;
    stop = 1'b0;
    o = '0;
    o.status = STS_OK;
    if (tbl_broken) begin
      o.status = STS_TABLE_BAD;
    end else begin
      case (r.cmd)
        CMD_LOAD: begin
          if (r.row >= cur_groups || r.slot >= GRP_SZ) begin
            o.status = STS_BAD_GROUP;
          end else begin
            group_tbl[r.row * GRP_SZ + r.slot] = r.song;
            if (r.song >= cur_songs) begin
              tbl_broken = 1'b1;
              o.status = STS_TABLE_BAD;
            end
          end
        end
        CMD_POP: begin
          if (song_fill == 0) begin
            o.status = STS_EMPTY;
          end else begin
            o.popped = song_mem[song_head];
            song_head = song_head + 1'b1;
            song_fill = song_fill - 1'b1;
            o.status = STS_POPPED;
            if (loop_on) begin
              store_song(o.popped);
              o.pushed = 2'd1;
            end
          end
        end
        CMD_TOGGLE: begin
          loop_on = !loop_on;
          o.status = loop_on ? STS_LOOP_ON : STS_LOOP_OFF;
        end
        CMD_PUSH: begin
          if (song_fill >= DEPTH) begin
            o.status = STS_FULL;
          end else if (r.song >= cur_songs) begin
            o.status = STS_BAD_ID;
          end else begin
            store_song(r.song);
            o.pushed = 2'd1;
          end
        end
        CMD_GROUP: begin
          if (r.row >= cur_groups) begin
            o.status = STS_BAD_GROUP;
          end else begin
            for (k = 0; k < GRP_SZ; k++) begin
              if (!stop) begin
                if (song_fill >= DEPTH) begin
                  o.status = STS_FULL;
                  stop = 1'b1;
                end else begin
                  store_song(group_tbl[r.row * GRP_SZ + k]);
                  o.pushed = o.pushed + 1'b1;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_res = out_tdata[$bits(res_t)-1:0];
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected no result, actual %h", $time, got_res);
        end else begin
          want_res = pending_results.pop_front();
          if (got_res.status !== want_res.status) begin
            mismatches++;
            $display("%0t: status expected %0d actual %0d", $time, want_res.status,
                     got_res.status);
          end
          if (got_res.popped !== want_res.popped) begin
            mismatches++;
            $display("%0t: popped_id expected %0d actual %0d", $time, want_res.popped,
                     got_res.popped);
          end
          if (got_res.pushed !== want_res.pushed) begin
            mismatches++;
            $display("%0t: pushed_count expected %0d actual %0d", $time, want_res.pushed,
                     got_res.pushed);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NUM_SONGS) cur_songs = cfg_data;
        else if (cfg_index == CFG_NUM_GROUPS) cur_groups = cfg_data[NGROUPS_W-1:0];
      end
      if (in_tvalid && in_tready) begin
        advance_play_queue(in_tdata[$bits(req_t)-1:0], calc_res);
        pending_results.push_back(req_typed ? req_res : calc_res);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("looping_play_queue_top test failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= stall_pct);
  end

  // all driver tasks are entered and left at a falling edge
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] i, input logic [CFG_DATA_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = i;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (i == CFG_NUM_SONGS) drv_songs = d;
    else drv_groups = d[NGROUPS_W-1:0];
  endtask

  task automatic send_req(input req_t r, input logic typed, input res_t res);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = {{(IN_DATA_W - $bits(req_t)){1'b0}}, r};
    req_typed = typed;
    req_res   = res;
    if (r.cmd == CMD_LOAD && r.row < drv_groups && r.slot < GRP_SZ)
      row_loaded[r.row][r.slot] = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic run_step(input step_t s);
    if (s.is_cfg) begin
      drain();
      write_reg(s.idx, s.data);
    end else begin
      send_req(s.r, s.typed, s.res);
    end
  endtask

  // random request; group pushes only read rows that are fully loaded
  task automatic make_req(output req_t r);
    int              pick;
    logic [ID_W-1:0] good_id;
    r.cmd  = CMD_SPARE_LO;
    r.song = ID_W'($urandom);
    r.row  = ROW_W'($urandom);
    r.slot = SLOT_W'($urandom);
    good_id = ID_W'($urandom_range(drv_songs - 1, 0));
    pick = $urandom_range(99);
    if (pick < 10) begin
      r.cmd = CMD_LOAD;
      if (drv_groups != 0 && $urandom_range(99) < 80) begin
        r.row  = ROW_W'($urandom_range(drv_groups - 1, 0));
        r.slot = SLOT_W'($urandom_range(GRP_SZ - 1, 0));
        r.song = good_id;
      end else if (drv_groups < 16 && $urandom_range(1)) begin
        r.row = ROW_W'($urandom_range(15, drv_groups));
      end else begin
        r.slot = 2'd3;
      end
    end else if (pick < (push_heavy ? 30 : 55)) begin
      r.cmd = CMD_POP;
    end else if (pick < (push_heavy ? 35 : 60)) begin
      r.cmd = CMD_TOGGLE;
    end else if (pick < (push_heavy ? 77 : 82)) begin
      r.cmd = CMD_PUSH;
      if ($urandom_range(99) < 85) r.song = good_id;
      else r.song = ID_W'($urandom_range(65535, drv_songs));
    end else if (pick < 97) begin
      r.cmd = CMD_GROUP;
      if (drv_groups != 0 && $urandom_range(99) < 85)
        r.row = ROW_W'($urandom_range(drv_groups - 1, 0));
      if (r.row < drv_groups && row_loaded[r.row] != 3'b111) begin
        r.cmd  = CMD_LOAD;
        r.song = good_id;
        r.slot = row_loaded[r.row][0] ? (row_loaded[r.row][1] ? 2'd2 : 2'd1) : 2'd0;
      end
    end else begin
      r.cmd = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
    end
  endtask

  function automatic step_t typed_row(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] s,
                                      input logic [ROW_W-1:0] g, input logic [SLOT_W-1:0] sl,
                                      input logic [STATUS_W-1:0] st,
                                      input logic [ID_W-1:0] pid,
                                      input logic [PUSHED_W-1:0] pc);
    step_t t;
    t = '0;
    t.r.cmd = c;
    t.r.song = s;
    t.r.row = g;
    t.r.slot = sl;
    t.typed = 1'b1;
    t.res.status = st;
    t.res.popped = pid;
    t.res.pushed = pc;
    return t;
  endfunction

  function automatic step_t pred_row(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] s,
                                     input logic [ROW_W-1:0] g, input logic [SLOT_W-1:0] sl);
    step_t t;
    t = '0;
    t.r.cmd = c;
    t.r.song = s;
    t.r.row = g;
    t.r.slot = sl;
    return t;
  endfunction

  function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] i,
                                    input logic [CFG_DATA_W-1:0] d);
    step_t t;
    t = '0;
    t.is_cfg = 1'b1;
    t.idx = i;
    t.data = d;
    return t;
  endfunction

  initial begin
    int   i;
    int   p;
    int   n;
    int   n_open;
    int   ph_songs [PHASES];
    int   ph_groups [PHASES];
    int   ph_idle [PHASES];
    int   ph_stall [PHASES];
    req_t r;

    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_typed = 1'b0;
    req_res = '0;
    song_head = '0;
    song_tail = '0;
    song_fill = '0;
    loop_on = 1'b0;
    tbl_broken = 1'b0;
    cur_songs = 16'd1;
    cur_groups = '0;
    drv_songs = 16'd1;
    drv_groups = '0;
    push_heavy = 1'b1;
    send_idle = 0;
    stall_pct = 0;
    mismatches = 0;
    cycle_count = 0;
    for (i = 0; i < DEPTH; i++) song_mem[i] = '0;
    for (i = 0; i < 16 * GRP_SZ; i++) group_tbl[i] = '0;
    for (i = 0; i < 16; i++) row_loaded[i] = '0;

    ph_songs  = '{1, 65535, 5, 300, 2, 40000, 16, 65535};
    ph_groups = '{1, 16, 3, 16, 0, 8, 16, 1};
    ph_idle   = '{0, 77, 0, 24, 0, 77, 0, 24};
    ph_stall  = '{0, 0, 77, 24, 0, 0, 77, 24};

    // opening rows, from the reset settings of one song and no groups
    steps.push_back(typed_row(CMD_POP, 16'd0, 4'd0, 2'd0, STS_EMPTY, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_PUSH, 16'd0, 4'd0, 2'd0, STS_OK, 16'd0, 2'd1));
    steps.push_back(typed_row(CMD_PUSH, 16'd1, 4'd0, 2'd0, STS_BAD_ID, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_LOAD, 16'd0, 4'd0, 2'd0, STS_BAD_GROUP, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_GROUP, 16'd0, 4'd0, 2'd0, STS_BAD_GROUP, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_TOGGLE, 16'd0, 4'd0, 2'd0, STS_LOOP_ON, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_POP, 16'd0, 4'd0, 2'd0, STS_POPPED, 16'd0, 2'd1));
    steps.push_back(typed_row(CMD_TOGGLE, 16'd0, 4'd0, 2'd0, STS_LOOP_OFF, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_SPARE_LO, 16'hffff, 4'd15, 2'd3, STS_OK, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_SPARE_HI, 16'd0, 4'd0, 2'd0, STS_OK, 16'd0, 2'd0));
    steps.push_back(cfg_row(CFG_NUM_SONGS, 16'hffff));
    steps.push_back(cfg_row(CFG_NUM_GROUPS, 16'd16));
    steps.push_back(typed_row(CMD_LOAD, 16'hfffe, 4'd15, 2'd0, STS_OK, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_LOAD, 16'd0, 4'd15, 2'd1, STS_OK, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_LOAD, 16'haaaa, 4'd15, 2'd2, STS_OK, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_LOAD, 16'hffff, 4'd0, 2'd3, STS_BAD_GROUP, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_PUSH, 16'hffff, 4'd0, 2'd0, STS_BAD_ID, 16'd0, 2'd0));
    steps.push_back(pred_row(CMD_PUSH, 16'h5555, 4'd0, 2'd0));
    // four full groups, then one that runs into the full queue
    for (i = 0; i < 5; i++) steps.push_back(pred_row(CMD_GROUP, 16'd0, 4'd15, 2'd0));
    steps.push_back(typed_row(CMD_PUSH, 16'hffff, 4'd0, 2'd0, STS_FULL, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_GROUP, 16'd0, 4'd15, 2'd0, STS_FULL, 16'd0, 2'd0));
    steps.push_back(pred_row(CMD_POP, 16'd0, 4'd0, 2'd0));
    steps.push_back(cfg_row(CFG_NUM_SONGS, 16'd0));
    steps.push_back(typed_row(CMD_PUSH, 16'd0, 4'd0, 2'd0, STS_BAD_ID, 16'd0, 2'd0));
    n_open = steps.size();
    // closing rows: a bad table id locks every later request
    steps.push_back(cfg_row(CFG_NUM_GROUPS, 16'd16));
    steps.push_back(cfg_row(CFG_NUM_SONGS, 16'd1));
    steps.push_back(typed_row(CMD_LOAD, 16'd1, 4'd3, 2'd1, STS_TABLE_BAD, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_LOAD, 16'd0, 4'd3, 2'd3, STS_TABLE_BAD, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_POP, 16'd0, 4'd0, 2'd0, STS_TABLE_BAD, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_TOGGLE, 16'd0, 4'd0, 2'd0, STS_TABLE_BAD, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_PUSH, 16'd0, 4'd0, 2'd0, STS_TABLE_BAD, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_GROUP, 16'd0, 4'd15, 2'd0, STS_TABLE_BAD, 16'd0, 2'd0));
    steps.push_back(typed_row(CMD_SPARE_MID, 16'd0, 4'd0, 2'd0, STS_TABLE_BAD, 16'd0, 2'd0));

    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    send_idle = 24;
    stall_pct = 24;
    for (i = 0; i < n_open; i++) run_step(steps[i]);

    for (p = 0; p < PHASES; p++) begin
      drain();
      write_reg(CFG_NUM_SONGS, CFG_DATA_W'(ph_songs[p]));
      write_reg(CFG_NUM_GROUPS, CFG_DATA_W'(ph_groups[p]));
      send_idle = ph_idle[p];
      stall_pct = ph_stall[p];
      for (n = 0; n < PHASE_LEN; n++) begin
        if (n % 24 == 0) push_heavy = 1'($urandom_range(1));
        if (n == PHASE_LEN / 2) drain();
        make_req(r);
        send_req(r, 1'b0, '0);
      end
    end

    send_idle = 24;
    stall_pct = 24;
    for (i = n_open; i < steps.size(); i++) run_step(steps[i]);
    drain();

    if (mismatches == 0) begin
      $display("looping_play_queue_top test passed");
    end else begin
      $display("looping_play_queue_top test failed");
    end
    $finish;
  end

endmodule
